@@ hdl/cna_pkg.sv @@
`default_nettype none
// ============================================================================
// cna_pkg: shared types and constants of the complex-number ALU
// Action codes, the per-stage pipeline record, fixed widths of the divider
// and CORDIC datapaths, and the CORDIC arctangent table.
// ============================================================================
package cna_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    // Divider: 33 quotient bits, the top one only flags a result of 2^32 or more.
    localparam int DIV_STEPS = 33;
    // Remainder width covers a 64-bit dividend shifted by up to 32 fraction bits.
    localparam int REM_W     = 96;

    // CORDIC: 24 guard bits over a 32-bit magnitude, plus headroom for the gain.
    localparam int GUARD = 24;
    localparam int CX_W  = 60;
    localparam int Z_W   = 36;

    localparam logic [31:0]           INV_GAIN = 32'h9B74EDA8;
    localparam logic signed [Z_W-1:0] PI_Q32   = 36'sd13493037705;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_CONJ  = 3'd4,
        ACT_MAG   = 3'd5,
        ACT_ARG   = 3'd6,
        ACT_EQUAL = 3'd7
    } act_t;

    // Everything one beat carries through the iteration stages.
    typedef struct packed {
        act_t                   act;
        logic signed [31:0]     rr;
        logic signed [31:0]     ri;
        logic                   eq;
        logic                   zd;
        logic                   ov;
        logic                   xneg;
        logic                   xzero;
        logic [63:0]            den;
        logic [REM_W-1:0]       rem_re;
        logic [REM_W-1:0]       rem_im;
        logic [DIV_STEPS-1:0]   q_re;
        logic [DIV_STEPS-1:0]   q_im;
        logic                   neg_re;
        logic                   neg_im;
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [Z_W-1:0]  cz;
    } item_t;

    // Arctangent of 2^-i in Q32 radians.
    function automatic logic [Z_W-1:0] atan_step(input int i);
        logic [Z_W-1:0] val;
        case (i)
            0:       val = 36'd3373259426;
            1:       val = 36'd1991351318;
            2:       val = 36'd1052175346;
            3:       val = 36'd534100635;
            4:       val = 36'd268086748;
            5:       val = 36'd134174063;
            6:       val = 36'd67103403;
            7:       val = 36'd33553749;
            8:       val = 36'd16777131;
            9:       val = 36'd8388597;
            10:      val = 36'd4194303;
            default: val = (i <= 32) ? (36'd1 << (32 - i)) : 36'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

@@ hdl/cna_iter_stage.sv @@
`default_nettype none
// ============================================================================
// cna_iter_stage: one registered step of the divider and the CORDIC
// Performs one restoring-division step on both quotient parts and, for the
// first CORDIC_STEPS stages, one vectoring CORDIC rotation.
// ============================================================================
module cna_iter_stage
    import cna_pkg::*;
#(
    parameter int STEP         = 0,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output logic       out_valid,
    output item_t      out_item
);

    localparam int SHIFT = DIV_STEPS - 1 - STEP;
    localparam logic signed [Z_W-1:0] ATAN = atan_step(STEP);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    logic [REM_W-1:0] den_sh;
    logic             ge_re;
    logic             ge_im;

    // Divider step: subtract the shifted divisor where it fits.
    assign den_sh = {{(REM_W-64){1'b0}}, in_item.den} << SHIFT;
    assign ge_re  = in_item.rem_re >= den_sh;
    assign ge_im  = in_item.rem_im >= den_sh;

    always_comb begin
        item_next        = in_item;
        item_next.rem_re = ge_re ? (in_item.rem_re - den_sh) : in_item.rem_re;
        item_next.rem_im = ge_im ? (in_item.rem_im - den_sh) : in_item.rem_im;
        item_next.q_re   = {in_item.q_re[DIV_STEPS-2:0], ge_re};
        item_next.q_im   = {in_item.q_im[DIV_STEPS-2:0], ge_im};
        // CORDIC rotation toward the positive real axis.
        if (STEP < CORDIC_STEPS) begin
            if (!in_item.cy[CX_W-1]) begin
                item_next.cx = in_item.cx + (in_item.cy >>> STEP);
                item_next.cy = in_item.cy - (in_item.cx >>> STEP);
                item_next.cz = in_item.cz + ATAN;
            end else begin
                item_next.cx = in_item.cx - (in_item.cy >>> STEP);
                item_next.cy = in_item.cy + (in_item.cx >>> STEP);
                item_next.cz = in_item.cz - ATAN;
            end
        end
    end

    // Valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

@@ hdl/complex_number_alu.sv @@
`default_nettype none
// ============================================================================
// complex_number_alu: pipelined complex arithmetic unit in signed fixed point
// Add, subtract, multiply, divide, conjugate, magnitude, argument, compare.
// ============================================================================
// Usage:
// The input channel (s_valid, s_ready) takes one beat per cycle while no
// result is held, with an action code and two complex operands x and y.
// The result channel (m_valid, m_ready) returns one beat per input beat,
// in order. The pipeline has 40 register stages. Throughput is one beat
// per cycle unless the result side stalls; the length is set by the 33
// restoring-division steps, one per stage, which also carry the CORDIC
// rotations for magnitude and argument.
// The whole pipeline advances together: when the receiver holds m_ready low
// with a result waiting, every stage holds and s_ready drops, so nothing is
// lost or repeated. s_ready follows m_ready combinationally, so a new beat
// is taken in the same cycle in which the waiting result is taken.
// A synchronous low aresetn clears all valid bits; data registers keep
// whatever they hold and are ignored until refilled.
// ============================================================================
module complex_number_alu
    import cna_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic signed [31:0] s_x_re,
    input  wire logic signed [31:0] s_x_im,
    input  wire logic signed [31:0] s_y_re,
    input  wire logic signed [31:0] s_y_im,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_re,
    output logic signed [31:0]      m_res_im,
    output logic                    m_is_equal,
    output logic                    m_zero_divisor,
    output logic                    m_overflow
);

    localparam int                    ARG_SHIFT = 32 - FRAC_BITS;
    localparam logic signed [Z_W-1:0] ARG_RND   = Z_W'(64'd1 << (31 - FRAC_BITS));
    localparam logic signed [31:0]    MAX32     = 32'sh7FFFFFFF;
    localparam logic signed [31:0]    MIN32     = 32'sh80000000;

    // Saturate a 65-bit signed value to 32 bits; the top bit flags overflow.
    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic ovf;
        ovf = !((&v[64:31]) || !(|v[64:31]));
        if (ovf) begin
            return {1'b1, v[64] ? MIN32 : MAX32};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Signed, saturated quotient from its 33-bit magnitude.
    function automatic logic [32:0] div_fin(input logic [DIV_STEPS-1:0] q, input logic neg);
        if (q[32]) begin
            return {1'b1, neg ? MIN32 : MAX32};
        end
        if (!neg) begin
            return q[31] ? {1'b1, MAX32} : {1'b0, q[31:0]};
        end
        if (q[31] && (|q[30:0])) begin
            return {1'b1, MIN32};
        end
        return {1'b0, 32'd0 - q[31:0]};
    endfunction

    logic m_valid_reg;
    logic en;

    // Whole pipeline moves when the output register is free or being taken.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------- stage 1
    logic               s1_valid_reg;
    act_t               s1_act_reg;
    logic signed [31:0] s1_xr_reg;
    logic signed [31:0] s1_xi_reg;
    logic signed [31:0] s1_yr_reg;
    logic signed [31:0] s1_yi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_act_reg <= act_t'(s_action);
            s1_xr_reg  <= s_x_re;
            s1_xi_reg  <= s_x_im;
            s1_yr_reg  <= s_y_re;
            s1_yi_reg  <= s_y_im;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic               s2_valid_reg;
    item_t              s2_item_reg;
    item_t              s2_item_next;
    logic signed [63:0] s2_p_rr_reg;
    logic signed [63:0] s2_p_ii_reg;
    logic signed [63:0] s2_p_ri_reg;
    logic signed [63:0] s2_p_ir_reg;
    logic signed [63:0] s2_sq_r_reg;
    logic signed [63:0] s2_sq_i_reg;

    logic signed [32:0] sum_a;
    logic signed [32:0] sum_b;
    logic [32:0]        sat_a;
    logic [32:0]        sat_b;
    logic [31:0]        abs_x;
    logic [31:0]        abs_y;

    // Short operations and CORDIC start values.
    always_comb begin
        case (s1_act_reg)
            ACT_SUB: begin
                sum_a = {s1_xr_reg[31], s1_xr_reg} - {s1_yr_reg[31], s1_yr_reg};
                sum_b = {s1_xi_reg[31], s1_xi_reg} - {s1_yi_reg[31], s1_yi_reg};
            end
            ACT_CONJ: begin
                sum_a = {s1_xr_reg[31], s1_xr_reg};
                sum_b = 33'sd0 - {s1_xi_reg[31], s1_xi_reg};
            end
            default: begin
                sum_a = {s1_xr_reg[31], s1_xr_reg} + {s1_yr_reg[31], s1_yr_reg};
                sum_b = {s1_xi_reg[31], s1_xi_reg} + {s1_yi_reg[31], s1_yi_reg};
            end
        endcase
        sat_a = sat65({{32{sum_a[32]}}, sum_a});
        sat_b = sat65({{32{sum_b[32]}}, sum_b});
        abs_x = s1_xr_reg[31] ? (32'd0 - s1_xr_reg) : s1_xr_reg;
        abs_y = s1_xi_reg[31] ? (32'd0 - s1_xi_reg) : s1_xi_reg;

        s2_item_next       = '0;
        s2_item_next.act   = s1_act_reg;
        s2_item_next.xneg  = s1_xr_reg[31];
        s2_item_next.xzero = (abs_x == 32'd0) && (abs_y == 32'd0);
        s2_item_next.cx    = {{(CX_W-32-GUARD){1'b0}}, abs_x, {GUARD{1'b0}}};
        s2_item_next.cy    = {{(CX_W-32-GUARD){1'b0}}, abs_y, {GUARD{1'b0}}};
        case (s1_act_reg)
            ACT_ADD, ACT_SUB, ACT_CONJ: begin
                s2_item_next.rr = sat_a[31:0];
                s2_item_next.ri = sat_b[31:0];
                s2_item_next.ov = sat_a[32] | sat_b[32];
            end
            ACT_EQUAL: begin
                s2_item_next.eq = (s1_xr_reg == s1_yr_reg) && (s1_xi_reg == s1_yi_reg);
            end
            default: begin
                s2_item_next.ov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_item_reg <= s2_item_next;
            s2_p_rr_reg <= s1_xr_reg * s1_yr_reg;
            s2_p_ii_reg <= s1_xi_reg * s1_yi_reg;
            s2_p_ri_reg <= s1_xr_reg * s1_yi_reg;
            s2_p_ir_reg <= s1_xi_reg * s1_yr_reg;
            s2_sq_r_reg <= s1_yr_reg * s1_yr_reg;
            s2_sq_i_reg <= s1_yi_reg * s1_yi_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic               s3_valid_reg;
    item_t              s3_item_reg;
    logic signed [64:0] s3_mul_re_reg;
    logic signed [64:0] s3_mul_im_reg;
    logic signed [64:0] s3_num_re_reg;
    logic signed [64:0] s3_num_im_reg;
    logic [63:0]        s3_den_reg;

    // Product sums for multiply, divide numerators and the divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_item_reg   <= s2_item_reg;
            s3_mul_re_reg <= {s2_p_rr_reg[63], s2_p_rr_reg} - {s2_p_ii_reg[63], s2_p_ii_reg};
            s3_mul_im_reg <= {s2_p_ri_reg[63], s2_p_ri_reg} + {s2_p_ir_reg[63], s2_p_ir_reg};
            s3_num_re_reg <= {s2_p_rr_reg[63], s2_p_rr_reg} + {s2_p_ii_reg[63], s2_p_ii_reg};
            s3_num_im_reg <= {s2_p_ir_reg[63], s2_p_ir_reg} - {s2_p_ri_reg[63], s2_p_ri_reg};
            s3_den_reg    <= s2_sq_r_reg + s2_sq_i_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic               s4_valid_reg;
    item_t              s4_item_reg;
    item_t              s4_item_next;

    logic signed [64:0] mul_sh_re;
    logic signed [64:0] mul_sh_im;
    logic [32:0]        mul_sat_re;
    logic [32:0]        mul_sat_im;
    logic [64:0]        mag_re;
    logic [64:0]        mag_im;

    // Multiply result, and divider and CORDIC starting points.
    always_comb begin
        mul_sh_re  = s3_mul_re_reg >>> FRAC_BITS;
        mul_sh_im  = s3_mul_im_reg >>> FRAC_BITS;
        mul_sat_re = sat65(mul_sh_re);
        mul_sat_im = sat65(mul_sh_im);
        mag_re     = s3_num_re_reg[64] ? (65'd0 - s3_num_re_reg) : s3_num_re_reg;
        mag_im     = s3_num_im_reg[64] ? (65'd0 - s3_num_im_reg) : s3_num_im_reg;

        s4_item_next        = s3_item_reg;
        s4_item_next.den    = s3_den_reg;
        s4_item_next.neg_re = s3_num_re_reg[64];
        s4_item_next.neg_im = s3_num_im_reg[64];
        s4_item_next.rem_re = {{(REM_W-64){1'b0}}, mag_re[63:0]} << FRAC_BITS;
        s4_item_next.rem_im = {{(REM_W-64){1'b0}}, mag_im[63:0]} << FRAC_BITS;
        s4_item_next.q_re   = '0;
        s4_item_next.q_im   = '0;
        s4_item_next.cz     = '0;
        if (s3_item_reg.act == ACT_MUL) begin
            s4_item_next.rr = mul_sat_re[31:0];
            s4_item_next.ri = mul_sat_im[31:0];
            s4_item_next.ov = mul_sat_re[32] | mul_sat_im[32];
        end
        if (s3_item_reg.act == ACT_DIV) begin
            s4_item_next.zd = (s3_den_reg == 64'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_item_reg <= s4_item_next;
        end
    end

    // Front valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------- iteration stages
    item_t chain_item  [0:DIV_STEPS];
    logic  chain_valid [0:DIV_STEPS];

    assign chain_item[0]  = s4_item_reg;
    assign chain_valid[0] = s4_valid_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_iter
        cna_iter_stage #(
            .STEP         (k),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    // ---------------------------------------------------------- post stage 1
    logic                  p1_valid_reg;
    item_t                 p1_item_reg;
    item_t                 p1_item_next;
    logic [63:0]           p1_lo_reg;
    logic [CX_W-1:0]       p1_hi_reg;
    logic signed [Z_W-1:0] p1_zadj_reg;
    logic signed [Z_W-1:0] p1_zadj_next;

    logic [32:0]           div_re;
    logic [32:0]           div_im;
    logic signed [Z_W-1:0] z_clamp;
    item_t                 last_item;

    assign last_item = chain_item[DIV_STEPS];

    // Quotient sign and saturation; angle folding.
    always_comb begin
        div_re       = div_fin(last_item.q_re, last_item.neg_re);
        div_im       = div_fin(last_item.q_im, last_item.neg_im);
        p1_item_next = last_item;
        if ((last_item.act == ACT_DIV) && !last_item.zd) begin
            p1_item_next.rr = div_re[31:0];
            p1_item_next.ri = div_im[31:0];
            p1_item_next.ov = div_re[32] | div_im[32];
        end
        z_clamp      = last_item.cz[Z_W-1] ? '0 : last_item.cz;
        p1_zadj_next = last_item.xneg ? (PI_Q32 - z_clamp) : z_clamp;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= p1_item_next;
            p1_lo_reg   <= last_item.cx[31:0] * INV_GAIN;
            p1_hi_reg   <= last_item.cx[CX_W-1:32] * INV_GAIN;
            p1_zadj_reg <= p1_zadj_next;
        end
    end

    // ---------------------------------------------------------- post stage 2
    logic                  p2_valid_reg;
    item_t                 p2_item_reg;
    logic [CX_W:0]         p2_mag_reg;
    logic [CX_W:0]         p2_mag_next;
    logic [31:0]           p2_arg_reg;
    logic [31:0]           p2_arg_next;
    logic signed [Z_W-1:0] arg_sum;
    logic signed [Z_W-1:0] arg_sh;

    // Gain correction sum and angle rounding.
    always_comb begin
        p2_mag_next = {1'b0, p1_hi_reg} + {{(CX_W-31){1'b0}}, p1_lo_reg[63:32]};
        arg_sum     = p1_zadj_reg + ARG_RND;
        arg_sh      = arg_sum >>> ARG_SHIFT;
        p2_arg_next = arg_sh[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_item_reg <= p1_item_reg;
            p2_mag_reg  <= p2_mag_next;
            p2_arg_reg  <= p2_arg_next;
        end
    end

    // ------------------------------------------------------- output register
    logic signed [31:0] m_res_re_reg;
    logic signed [31:0] m_res_im_reg;
    logic               m_is_equal_reg;
    logic               m_zero_divisor_reg;
    logic               m_overflow_reg;
    logic signed [31:0] m_res_re_next;
    logic signed [31:0] m_res_im_next;
    logic               m_is_equal_next;
    logic               m_zero_divisor_next;
    logic               m_overflow_next;
    logic               mag_sat;

    // Final selection of magnitude and argument results.
    always_comb begin
        mag_sat             = |p2_mag_reg[CX_W:GUARD+31];
        m_res_re_next       = p2_item_reg.rr;
        m_res_im_next       = p2_item_reg.ri;
        m_is_equal_next     = p2_item_reg.eq;
        m_zero_divisor_next = p2_item_reg.zd;
        m_overflow_next     = p2_item_reg.ov;
        case (p2_item_reg.act)
            ACT_MAG: begin
                m_res_im_next   = '0;
                m_res_re_next   = p2_item_reg.xzero ? 32'sd0 :
                                  (mag_sat ? MAX32 : p2_mag_reg[GUARD+31:GUARD]);
                m_overflow_next = !p2_item_reg.xzero && mag_sat;
            end
            ACT_ARG: begin
                m_res_im_next       = '0;
                m_res_re_next       = p2_item_reg.xzero ? 32'sd0 : p2_arg_reg;
                m_zero_divisor_next = p2_item_reg.xzero;
                m_overflow_next     = 1'b0;
            end
            default: begin
                m_res_re_next = p2_item_reg.rr;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_re_reg       <= m_res_re_next;
            m_res_im_reg       <= m_res_im_next;
            m_is_equal_reg     <= m_is_equal_next;
            m_zero_divisor_reg <= m_zero_divisor_next;
            m_overflow_reg     <= m_overflow_next;
        end
    end

    // Back valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= chain_valid[DIV_STEPS];
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_res_re       = m_res_re_reg;
    assign m_res_im       = m_res_im_reg;
    assign m_is_equal     = m_is_equal_reg;
    assign m_zero_divisor = m_zero_divisor_reg;
    assign m_overflow     = m_overflow_reg;

`ifndef NO_ASSERTIONS
    // A zero divisor or zero argument operand always returns zero parts.
    a_zd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_divisor) |-> (m_res_re == 32'sd0 && m_res_im == 32'sd0))
        else $error("zero divisor with nonzero result");

    // A compare hit carries no other result or flag.
    a_eq_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_equal) |->
            (m_res_re == 32'sd0 && m_res_im == 32'sd0 && !m_zero_divisor && !m_overflow))
        else $error("compare result with stray fields");

    // Saturation and zero divisor never coincide.
    a_zd_ov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_zero_divisor && m_overflow))
        else $error("zero divisor and overflow together");

    // A held result keeps the pipeline frozen; checked on the s1 and p2 valid bits.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(p2_valid_reg) && $stable(s1_valid_reg)))
        else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ============================================================================
// tb: self-checking testbench for the complex-number ALU
// Drives directed corner operands and then random ones through the valid/ready
// input channel, with random gaps and result stalls. A scoreboard predicts
// every result and compares each result beat, in order, field by field.
// ============================================================================
module tb;
    import cna_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic               zd;
        logic               ov;
    } answer_t;

    // Scoreboard: predicts the ALU and holds the answers still in flight.
    class alu_scoreboard;
        answer_t awaited[$];
        int      errors = 0;
        longint  atan_q32[11] = '{64'd3373259426, 64'd1991351318, 64'd1052175346,
                                  64'd534100635, 64'd268086748, 64'd134174063,
                                  64'd67103403, 64'd33553749, 64'd16777131,
                                  64'd8388597, 64'd4194303};

        function logic signed [31:0] clip(wide_t v, inout logic ov);
            if (v > 128'sd2147483647) begin
                ov = 1;
                return 32'sh7FFFFFFF;
            end
            if (v < -128'sd2147483648) begin
                ov = 1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        // Truncating fixed-point quotient of num / den with saturation.
        function logic signed [31:0] quotient(wide_t num, wide_t den, inout logic ov);
            wide_t mag;
            wide_t q;
            mag = (num < 0) ? -num : num;
            q = (mag <<< 16) / den;
            if (q >= 128'sd4294967296) q = 128'sd4294967296;
            return clip((num < 0) ? -q : q, ov);
        endfunction

        function answer_t compute(act_t a, logic signed [31:0] x_re,
                                  logic signed [31:0] x_im, logic signed [31:0] y_re,
                                  logic signed [31:0] y_im);
            wide_t   xr, xi, yr, yi, den, ax, ay, m;
            longint  cx, cy, cz, dx, dy, step;
            answer_t r;
            xr = x_re;
            xi = x_im;
            yr = y_re;
            yi = y_im;
            r = '{re: 0, im: 0, eq: 0, zd: 0, ov: 0};
            case (a)
                ACT_ADD: begin
                    r.re = clip(xr + yr, r.ov);
                    r.im = clip(xi + yi, r.ov);
                end
                ACT_SUB: begin
                    r.re = clip(xr - yr, r.ov);
                    r.im = clip(xi - yi, r.ov);
                end
                ACT_MUL: begin
                    r.re = clip((xr * yr - xi * yi) >>> 16, r.ov);
                    r.im = clip((xr * yi + xi * yr) >>> 16, r.ov);
                end
                ACT_DIV: begin
                    den = yr * yr + yi * yi;
                    if (den == 0) begin
                        r.zd = 1;
                    end else begin
                        r.re = quotient(xr * yr + xi * yi, den, r.ov);
                        r.im = quotient(xi * yr - xr * yi, den, r.ov);
                    end
                end
                ACT_CONJ: begin
                    r.re = x_re;
                    r.im = clip(-xi, r.ov);
                end
                ACT_MAG, ACT_ARG: begin
                    ax = (xr < 0) ? -xr : xr;
                    ay = (xi < 0) ? -xi : xi;
                    if (ax == 0 && ay == 0) begin
                        r.zd = (a == ACT_ARG);
                    end else begin
                        // Vectoring rotations drive y toward zero.
                        cx = longint'(ax <<< 24);
                        cy = longint'(ay <<< 24);
                        cz = 0;
                        for (int i = 0; i < 20; i++) begin
                            dx = cy >>> i;
                            dy = cx >>> i;
                            step = (i < 11) ? atan_q32[i] : (64'sd1 <<< (32 - i));
                            if (cy >= 0) begin
                                cx += dx;
                                cy -= dy;
                                cz += step;
                            end else begin
                                cx -= dx;
                                cy += dy;
                                cz -= step;
                            end
                        end
                        if (a == ACT_MAG) begin
                            m = (wide_t'(cx) * 128'sh9B74EDA8) >>> 56;
                            if (m > 128'sd2147483647) begin
                                m = 128'sd2147483647;
                                r.ov = 1;
                            end
                            r.re = m[31:0];
                        end else begin
                            if (cz < 0) cz = 0;
                            if (xr < 0) cz = 64'sd13493037705 - cz;
                            r.re = 32'((cz + 64'sd32768) >>> 16);
                        end
                    end
                end
                default: begin
                    r.eq = (xr == yr) && (xi == yi);
                end
            endcase
            return r;
        endfunction

        function void note(act_t a, logic signed [31:0] xr, logic signed [31:0] xi,
                           logic signed [31:0] yr, logic signed [31:0] yi);
            awaited.push_back(compute(a, xr, xi, yr, yi));
        endfunction

        function void check(answer_t got);
            answer_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat with no answer pending: re=%0d im=%0d",
                             got.re, got.im);
                return;
            end
            want = awaited.pop_front();
            if (got.re !== want.re || got.im !== want.im || got.eq !== want.eq ||
                got.zd !== want.zd || got.ov !== want.ov) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected re=%0d im=%0d eq=%0b zd=%0b ov=%0b,",
                              " got re=%0d im=%0d eq=%0b zd=%0b ov=%0b"},
                             want.re, want.im, want.eq, want.zd, want.ov,
                             got.re, got.im, got.eq, got.zd, got.ov);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_action = '0;
    logic signed [31:0] s_x_re = '0;
    logic signed [31:0] s_x_im = '0;
    logic signed [31:0] s_y_re = '0;
    logic signed [31:0] s_y_im = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_res_re;
    logic signed [31:0] m_res_im;
    logic               m_is_equal;
    logic               m_zero_divisor;
    logic               m_overflow;

    alu_scoreboard sb = new();
    bit            steady = 0;
    int            idle_cycles = 0;

    complex_number_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_x_re(s_x_re), .s_x_im(s_x_im), .s_y_re(s_y_re), .s_y_im(s_y_im),
        .m_valid(m_valid), .m_ready(m_ready), .m_res_re(m_res_re),
        .m_res_im(m_res_im), .m_is_equal(m_is_equal),
        .m_zero_divisor(m_zero_divisor), .m_overflow(m_overflow)
    );

    always #1 aclk = ~aclk;

    // Monitor: note each input beat and check each result beat at the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note(act_t'(s_action), s_x_re, s_x_im, s_y_re, s_y_im);
            if (m_valid && m_ready)
                sb.check('{re: m_res_re, im: m_res_im, eq: m_is_equal,
                           zd: m_zero_divisor, ov: m_overflow});
        end
    end

    // Watchdog: a long run of cycles without any handshake is a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    // Result side: before each beat, drop m_ready for a random gap, none in steady stretches.
    initial begin
        int w;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            w = draw_gap();
            if (w > 0) begin
                m_ready = 0;
                repeat (w) @(negedge aclk);
            end
            m_ready = 1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Present one beat after a random gap and hold it until it is taken.
    task automatic send(act_t a, logic signed [31:0] xr, logic signed [31:0] xi,
                        logic signed [31:0] yr, logic signed [31:0] yi);
        int g;
        g = draw_gap();
        if (g > 0) begin
            s_valid = 0;
            repeat (g) @(negedge aclk);
        end
        s_action = a;
        s_x_re = xr;
        s_x_im = xi;
        s_y_re = yr;
        s_y_im = yi;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            6: return 32'sh7FFFFFFF;
            7: return 32'sh80000000;
            8: return ($urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000);
            default: return 0;
        endcase
    endfunction

    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    initial begin
        act_t               a;
        logic signed [31:0] xr, xi, yr, yi;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed corners: extremes, zero divisor, zero argument, saturation.
        send(ACT_ADD, MAXV, MINV, ONE, -ONE);
        send(ACT_SUB, MINV, MAXV, ONE, -ONE);
        send(ACT_ADD, MINV, MINV, MINV, MINV);
        send(ACT_MUL, MAXV, MAXV, MAXV, MINV);
        send(ACT_MUL, MINV, MINV, MINV, MINV);
        send(ACT_MUL, -3, 5, 7, -1);
        send(ACT_DIV, ONE, ONE, 0, 0);
        send(ACT_DIV, MAXV, MINV, 1, 0);
        send(ACT_DIV, MINV, MINV, MINV, MINV);
        send(ACT_DIV, 3 * ONE, -ONE, ONE, 2 * ONE);
        send(ACT_CONJ, MAXV, MINV, 0, 0);
        send(ACT_CONJ, -5, 7, 0, 0);
        send(ACT_MAG, 0, 0, 0, 0);
        send(ACT_MAG, MINV, MINV, 0, 0);
        send(ACT_MAG, 3 * ONE, -4 * ONE, 0, 0);
        send(ACT_ARG, 0, 0, 0, 0);
        send(ACT_ARG, -ONE, 0, 0, 0);
        send(ACT_ARG, -ONE, 1, 0, 0);
        send(ACT_ARG, ONE, 0, 0, 0);
        send(ACT_ARG, 0, MINV, 0, 0);
        send(ACT_ARG, MAXV, -1, 0, 0);
        send(ACT_EQUAL, MINV, MAXV, MINV, MAXV);
        send(ACT_EQUAL, MINV, MAXV, MINV, MAXV - 1);

        // Random operations, with stretches of back-to-back traffic.
        for (int n = 0; n < 750; n++) begin
            steady = ((n / 100) % 3) == 2;
            a = act_t'($urandom_range(0, 7));
            xr = pick_operand();
            xi = pick_operand();
            yr = pick_operand();
            yi = pick_operand();
            if (a == ACT_EQUAL && $urandom_range(0, 1)) begin
                yr = xr;
                yi = xi;
            end
            send(a, xr, xi, yr, yi);
        end
        s_valid = 0;
        steady = 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/cna_pkg.sv
hdl/cna_iter_stage.sv
hdl/complex_number_alu.sv
dv/tb.sv
